// ===== hw/rtl/lkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 31;
  localparam int DATA_BITS = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int OCC_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int OP_W      = 2;
  localparam int FLAG_W    = 2;
  localparam int TDATA_W   = ((KEY_BITS + DATA_BITS + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] data_out;
    logic                 evicted;
    logic [KEY_BITS-1:0]  evicted_key;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkc_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkc_in_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire lkc_pkg::req_t req_i,
  output logic              valid_o,
  input  wire logic         take_i,
  output lkc_pkg::req_t     req_o
);
  import lkc_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;

  // Refill in the same cycle the held request moves on.
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lkc_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkc_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire lkc_pkg::res_t res_i,
  output logic               can_load_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output lkc_pkg::res_t      res_o
);
  import lkc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = can_load_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lkc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkc_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [lkc_pkg::CAP_W-1:0] cap_i,
  input  wire logic                     fire_i,
  input  wire lkc_pkg::req_t            req_i,
  output lkc_pkg::res_t                 res_o
);
  import lkc_pkg::*;

  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [KEY_BITS-1:0]  key_q  [ENTRIES];
  logic [DATA_BITS-1:0] data_q [ENTRIES];
  logic [IDX_W-1:0]     rank_q [ENTRIES];
  logic [IDX_W-1:0]     rank_d [ENTRIES];

  logic [ENTRIES-1:0]   hit_vec, victim_vec, remain_vec, free_vec, ins_vec;
  logic [DATA_BITS-1:0] hit_data;
  logic [KEY_BITS-1:0]  victim_key;
  logic [IDX_W-1:0]     hit_rank, last_rank;
  logic [OCC_W-1:0]     eff_cap;
  logic                 hit, is_find, is_write, is_del, op_ok;
  logic                 do_evict, do_insert;

  always_comb begin
    is_find  = 1'b0;
    is_write = 1'b0;
    is_del   = 1'b0;
    case (op_e'(req_i.opcode))
      OP_FIND:   is_find  = 1'b1;
      OP_WRITE:  is_write = 1'b1;
      OP_DELETE: is_del   = 1'b1;
      default:   ;
    endcase
  end
  assign op_ok = is_find || is_write || is_del;

  // Clamp capacity into 1..ENTRIES.
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_i > CAP_W'(ENTRIES)) begin
      eff_cap = OCC_W'(ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_i);
    end
  end

  // Ranks of valid entries are a permutation of 0..occ-1, so the least
  // recent entry is the one holding rank occ-1.
  assign last_rank = IDX_W'(occ_q - OCC_W'(1));

  always_comb begin
    hit_data   = '0;
    hit_rank   = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (key_q[i] == req_i.key);
      victim_vec[i] = valid_q[i] && (rank_q[i] == last_rank);
      hit_data      = hit_data   | (data_q[i] & {DATA_BITS{hit_vec[i]}});
      hit_rank      = hit_rank   | (rank_q[i] & {IDX_W{hit_vec[i]}});
      victim_key    = victim_key | (key_q[i]  & {KEY_BITS{victim_vec[i]}});
    end
  end

  assign hit        = |hit_vec;
  assign do_evict   = is_write && !hit && (occ_q >= eff_cap);
  assign remain_vec = valid_q & ~(do_evict ? victim_vec : '0);
  assign free_vec   = ~remain_vec;
  assign ins_vec    = free_vec & (~free_vec + ENTRIES'(1));
  assign do_insert  = is_write && !hit && (|free_vec);

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (fire_i) begin
      if (is_del && hit) begin
        valid_d = valid_q & ~hit_vec;
        occ_d   = occ_q - OCC_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] > hit_rank) rank_d[i] = rank_q[i] - IDX_W'(1);
        end
      end else if (is_write && hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && rank_q[i] < hit_rank) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
      end else if (do_insert) begin
        valid_d = remain_vec | ins_vec;
        if (!do_evict) occ_d = occ_q + OCC_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (ins_vec[i]) begin
            rank_d[i] = '0;
          end else if (remain_vec[i]) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_q[i] <= rank_d[i];
      if (fire_i && do_insert && ins_vec[i]) begin
        key_q[i]  <= req_i.key;
        data_q[i] <= req_i.data_in;
      end else if (fire_i && is_write && hit_vec[i]) begin
        data_q[i] <= req_i.data_in;
      end
    end
  end

  assign res_o.hit         = op_ok && hit;
  assign res_o.data_out    = (is_find && hit) ? hit_data : '0;
  assign res_o.evicted     = do_evict;
  assign res_o.evicted_key = do_evict ? victim_key : '0;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_W'($countones(valid_q)))
    else $error("occupancy out of step with valid bits");

  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("key stored in more than one entry");

  a_evict_keeps_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && do_evict) |=> (occ_q == $past(occ_q)))
    else $error("eviction changed occupancy");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.evicted |-> (!res_o.hit && (|victim_vec)))
    else $error("eviction without a miss or without a victim");

endmodule

`default_nettype wire

// ===== hw/rtl/lru_keyed_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fully associative keyed cache, 16 entries, least-recently-used eviction.
// Each stream transaction carries one request (find, write, delete) and
// produces exactly one result transaction. Throughput is one request per
// clock while the result stream is ready; back-pressure on it stalls the
// input. The request is held in the input register, then the lookup and the
// entry/rank update happen in a single pass over all 16 entries while the
// result is captured in the output register on the same edge. The 16-way
// key compare plus rank compare in that pass sets the cycle time. Write the
// capacity register only while the cache is idle; values 0 and above 16 act
// as 1 and 16. Valid bits and occupancy clear at reset, so no clearing pass
// is needed.
module lru_keyed_cache (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Capacity configuration
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lkc_pkg::CAP_W-1:0]   cfg_data_i,
  // Request stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [lkc_pkg::TDATA_W-1:0] s_axis_tdata,  // key, data_in, zero pad
  input  wire logic [lkc_pkg::OP_W-1:0]    s_axis_tuser,  // opcode
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [lkc_pkg::TDATA_W-1:0]      m_axis_tdata,  // data_out, evicted_key, zero pad
  output logic [lkc_pkg::FLAG_W-1:0]       m_axis_tuser   // hit, evicted
);
  import lkc_pkg::*;

  logic [CAP_W-1:0] cap_q, cap_d;
  req_t             in_req, held_req;
  res_t             core_res, out_res;
  logic             held_valid, out_can_load, advance;

  // Capacity register: always ready, updated on every write transaction.
  assign cfg_ready_o = 1'b1;
  assign cap_d       = cfg_valid_i ? cfg_data_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Unpack the request transaction.
  assign in_req.opcode  = s_axis_tuser;
  assign in_req.key     = s_axis_tdata[KEY_BITS-1:0];
  assign in_req.data_in = s_axis_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS];

  lkc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .req_i   (in_req),
    .valid_o (held_valid),
    .take_i  (advance),
    .req_o   (held_req)
  );

  // Advance the held request whenever the output register has room; the
  // cache state updates on that same edge.
  assign advance = held_valid && out_can_load;

  lkc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cap_i  (cap_q),
    .fire_i (advance),
    .req_i  (held_req),
    .res_o  (core_res)
  );

  lkc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (core_res),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

  // Pack the result transaction; pad bits drive zero.
  assign m_axis_tdata[DATA_BITS-1:0]                  = out_res.data_out;
  assign m_axis_tdata[DATA_BITS+KEY_BITS-1:DATA_BITS] = out_res.evicted_key;
  assign m_axis_tdata[TDATA_W-1:DATA_BITS+KEY_BITS]   = '0;
  assign m_axis_tuser[0]                              = out_res.hit;
  assign m_axis_tuser[1]                              = out_res.evicted;

endmodule

`default_nettype wire
